// ===== rtl/rdr_pkg.sv =====
// ----------------------------------------------------------------------------
// rdr_pkg: shared types and codes for the rational divide/reduce block
// Status codes, front-end queue entry and back-end FSM state encoding.
// ----------------------------------------------------------------------------
package rdr_pkg;

  localparam int unsigned MagW = 64;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // classified job handed from front to back
  typedef struct packed {
    logic              bypass;  // result is status only, no arithmetic
    status_t           status;
    logic              neg;
    logic [MagW-1:0]   mn;
    logic [MagW-1:0]   md;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_DONE
  } bstate_t;

endpackage

// ===== rtl/rdr_front.sv =====
// ----------------------------------------------------------------------------
// rdr_front: input classification and cross multiply
// Checks special cases, then forms 64-bit magnitudes in a registered multiply.
// ----------------------------------------------------------------------------
module rdr_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                kind,
  input  logic signed [31:0]  num_a,
  input  logic signed [31:0]  den_a,
  input  logic signed [31:0]  num_b,
  input  logic signed [31:0]  den_b,
  output logic                job_valid,
  input  logic                job_ready,
  output rdr_pkg::job_t       job
);
  import rdr_pkg::*;

  // stage 1: magnitudes and classification
  logic        s1_valid;
  logic        s1_bypass;
  status_t     s1_status;
  logic        s1_neg;
  logic        s1_mul;
  logic [31:0] s1_ma, s1_mda, s1_mb, s1_mdb;
  logic        s1_ready;

  logic [31:0] ma, mda, mb, mdb;
  assign ma  = num_a[31] ? 32'(-num_a) : 32'(num_a);
  assign mda = den_a[31] ? 32'(-den_a) : 32'(den_a);
  assign mb  = num_b[31] ? 32'(-num_b) : 32'(num_b);
  assign mdb = den_b[31] ? 32'(-den_b) : 32'(den_b);

  assign s1_ready = !job_valid || job_ready;
  assign full = s1_valid && !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!full) begin
      s1_valid <= push;
    end
    if (!full && push) begin
      s1_ma  <= ma;
      s1_mda <= mda;
      s1_mb  <= mb;
      s1_mdb <= mdb;
      s1_mul <= kind;
      if (den_a == 32'sd0 || (kind && den_b == 32'sd0)) begin
        s1_bypass <= 1'b1;
        s1_status <= ST_ZERO_DEN;
      end else if (kind && num_b == 32'sd0) begin
        s1_bypass <= 1'b1;
        s1_status <= ST_DIV_ZERO;
      end else begin
        s1_bypass <= 1'b0;
        s1_status <= ST_OK;
      end
      s1_neg <= kind ? (num_a[31] ^ den_b[31] ^ den_a[31] ^ num_b[31])
                     : (num_a[31] ^ den_a[31]);
    end
  end

  // stage 2: for a divide, one 32x32 product each for numerator and denominator
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s1_ready) begin
      job_valid <= s1_valid;
    end
    if (s1_ready && s1_valid) begin
      job.bypass <= s1_bypass;
      job.status <= s1_status;
      job.neg    <= s1_neg;
      job.mn     <= s1_mul ? s1_ma * s1_mdb : {32'd0, s1_ma};
      job.md     <= s1_mul ? s1_mda * s1_mb : {32'd0, s1_mda};
    end
  end
endmodule

// ===== rtl/rdr_fifo.sv =====
// ----------------------------------------------------------------------------
// rdr_fifo: two-entry job queue between front and back
// Lets classification proceed while the reduction unit is busy.
// ----------------------------------------------------------------------------
module rdr_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rdr_pkg::job_t in_job,
  output logic          out_valid,
  input  logic          out_ready,
  output rdr_pkg::job_t out_job
);
  import rdr_pkg::*;

  job_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_job   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
    if (in_valid && in_ready) mem[wp] <= in_job;
  end
endmodule

// ===== rtl/rdr_back.sv =====
// ----------------------------------------------------------------------------
// rdr_back: reduction unit
// Euclid by shift-subtract remainder, then two restoring divisions by gcd.
// ----------------------------------------------------------------------------
module rdr_back #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_ready,
  input  rdr_pkg::job_t        job,
  output logic                 empty,
  input  logic                 pop,
  output rdr_pkg::status_t     status,
  output logic signed [31:0]   num_out,
  output logic [30:0]          den_out
);
  import rdr_pkg::*;

  localparam logic [63:0] Limit = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;

  bstate_t     state, state_next;
  logic        neg;
  logic [63:0] mn, md;       // original magnitudes
  logic [63:0] ga, gb;       // gcd operands
  logic [63:0] rem;          // running remainder / partial remainder
  logic [63:0] quo;          // quotient shift register
  logic [63:0] dvd;          // dividend being shifted out
  logic [6:0]  step;         // 64 steps per remainder/division
  logic        gcd_mod;      // mid remainder computation
  logic [63:0] rn;           // reduced numerator

  logic [64:0] trial;
  logic [63:0] divisor;
  assign divisor = (state == S_GCD) ? gb : ga;
  assign trial = {rem, dvd[63]} - {1'b0, divisor};

  assign job_ready = (state == S_IDLE);
  assign empty = (state != S_DONE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (job_valid) state_next = job.bypass ? S_DONE : S_GCD;
      S_GCD:  if (!gcd_mod && gb == 64'd0) state_next = S_DIVN;
      S_DIVN: if (step == 7'd64) state_next = S_DIVD;
      S_DIVD: if (step == 7'd64) state_next = S_DONE;
      S_DONE: if (pop) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gcd_mod <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          gcd_mod <= 1'b0;
          if (job_valid) begin
            status  <= job.status;
            num_out <= '0;
            den_out <= '0;
            neg <= job.neg;
            mn  <= job.mn;
            md  <= job.md;
            ga  <= job.mn;
            gb  <= job.md;
          end
        end
        S_GCD: begin
          if (!gcd_mod) begin
            if (gb == 64'd0) begin
              // gcd is ga; zero only for 0/0 which never gets here
              if (ga == 64'd0) ga <= 64'd1;
              rem  <= '0;
              dvd  <= mn;
              step <= '0;
            end else begin
              gcd_mod <= 1'b1;
              rem  <= '0;
              dvd  <= ga;
              step <= '0;
            end
          end else if (step == 7'd64) begin
            ga <= gb;
            gb <= rem;
            gcd_mod <= 1'b0;
          end else begin
            if (!trial[64]) rem <= trial[63:0];
            else rem <= {rem[62:0], dvd[63]};
            dvd  <= {dvd[62:0], 1'b0};
            step <= step + 7'd1;
          end
        end
        S_DIVN, S_DIVD: begin
          if (step == 7'd64) begin
            if (state == S_DIVN) begin
              rn   <= quo;
              rem  <= '0;
              dvd  <= md;
              step <= '0;
            end else begin
              if (rn == 64'd0) begin
                status <= ST_OK;
                num_out <= '0;
                den_out <= 31'd1;
              end else if (rn > Limit || quo > Limit) begin
                status <= ST_OVERFLOW;
              end else begin
                status <= ST_OK;
                num_out <= neg ? 32'(-rn) : rn[31:0];
                den_out <= quo[30:0];
              end
            end
          end else begin
            if (!trial[64]) rem <= trial[63:0];
            else rem <= {rem[62:0], dvd[63]};
            quo  <= {quo[62:0], !trial[64]};
            dvd  <= {dvd[62:0], 1'b0};
            step <= step + 7'd1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/rational_divide_reduce_top.sv =====
// ----------------------------------------------------------------------------
// rational_divide_reduce_top: rational build/divide with gcd reduction
// Front classifies and cross multiplies, back reduces one job at a time.
// ----------------------------------------------------------------------------
// Special cases bypass the arithmetic; others run Euclid, then two divisions.
// The back end takes no new item until its last result is popped; each
//   Euclid remainder and each division is a 64-step shift-subtract.
// Reset: rst synchronous, clears queue and FSM; no result pending after it.
module rational_divide_reduce_top #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic                kind,
  input  logic signed [31:0]  num_a,
  input  logic signed [31:0]  den_a,
  input  logic signed [31:0]  num_b,
  input  logic signed [31:0]  den_b,
  output logic                empty,
  input  logic                pop,
  output logic [1:0]          status,
  output logic signed [31:0]  num_out,
  output logic [30:0]         den_out
);
  import rdr_pkg::*;

  job_t    f_job, q_job;
  logic    f_valid, f_ready, q_valid, q_ready;
  status_t st;

  rdr_front u_front (
    .clk, .rst, .push, .full, .kind, .num_a, .den_a, .num_b, .den_b,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  rdr_fifo u_fifo (
    .clk, .rst,
    .in_valid(f_valid), .in_ready(f_ready), .in_job(f_job),
    .out_valid(q_valid), .out_ready(q_ready), .out_job(q_job)
  );

  rdr_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk, .rst,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .empty, .pop, .status(st), .num_out, .den_out
  );

  assign status = st;

  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_OK) |-> den_out != 31'd0)
    else $error("ok result with zero denominator");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> (num_out == 32'sd0 && den_out == 31'd0))
    else $error("error result with nonzero fields");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(num_out) && $stable(status))
    else $error("pending result changed");
endmodule

// ===== test/tb_rational_divide_reduce_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_divide_reduce_top: self-checking bench for rational divide/reduce
// Directed table of builds and divides, then random fractions. Every result
// beat is checked, in order, against its typed or gcd-reduced expected result.
// ----------------------------------------------------------------------------
module tb_rational_divide_reduce_top;
  import rdr_pkg::*;

  localparam int VW = 32;
  localparam int NUM_RANDOM = 1400;
  localparam longint CYCLE_LIMIT = 64'd40000000;

  typedef struct {
    logic        kind;
    logic [31:0] na, da, nb, db;
  } frac_req_t;

  typedef struct {
    status_t     st;
    logic [31:0] num;
    logic [30:0] den;
  } frac_res_t;

  typedef struct {
    frac_req_t req;
    logic      known;  // expected result typed into the table
    frac_res_t res;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic kind = 1'b0;
  logic signed [31:0] num_a = '0, den_a = '0, num_b = '0, den_b = '0;
  logic pop = 1'b0;
  logic full, empty;
  logic [1:0] status;
  logic signed [31:0] num_out;
  logic [30:0] den_out;

  frac_res_t quotient_q[$];
  int mismatches = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  int hold_rx = 0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;

  always #2 clk = ~clk;

  rational_divide_reduce_top #(.VALUE_WIDTH(VW)) dut (
    .clk, .rst, .push, .full, .kind, .num_a, .den_a, .num_b, .den_b,
    .empty, .pop, .status, .num_out, .den_out
  );

  function automatic logic [63:0] gcd_of(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic frac_res_t reduce_frac(longint n, longint d);
    frac_res_t r;
    logic [63:0] mn, md, g, lim;
    logic neg;
    mn = n < 0 ? -n : n;
    md = d < 0 ? -d : d;
    neg = (n < 0) != (d < 0);
    lim = (64'd1 << (VW - 1)) - 1;
    g = gcd_of(mn, md);
    if (g == 0) g = 1;
    mn = mn / g;
    md = md / g;
    if (mn == 0) begin
      md = 1;
      neg = 1'b0;
    end
    r = '{ST_OK, '0, '0};
    if (mn > lim || md > lim) r.st = ST_OVERFLOW;
    else begin
      r.num = neg ? -mn[31:0] : mn[31:0];
      r.den = md[30:0];
    end
    return r;
  endfunction

  function automatic frac_res_t predict_quotient(frac_req_t q);
    frac_res_t r;
    longint na, da, nb, db;
    na = $signed(q.na); da = $signed(q.da);
    nb = $signed(q.nb); db = $signed(q.db);
    r = '{ST_OK, '0, '0};
    if (da == 0 || (q.kind && db == 0)) r.st = ST_ZERO_DEN;
    else if (!q.kind) r = reduce_frac(na, da);
    else if (nb == 0) r.st = ST_DIV_ZERO;
    else r = reduce_frac(na * db, da * nb);
    return r;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 12) - 6;
      1: return $urandom_range(0, 2000) - 1000;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000001;
      3: return $urandom_range(0, 1) ? 32'h80000000 : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic frac_req_t rand_req();
    frac_req_t q;
    logic [31:0] f;
    q.kind = 1'($urandom_range(0, 1));
    // shared factor keeps reductions nontrivial
    f = $urandom_range(1, 1000);
    q.na = rand_val(); q.da = rand_val(); q.nb = rand_val(); q.db = rand_val();
    if ($urandom_range(0, 2) == 0) begin
      q.na = q.na[15:0] * f;
      q.da = ($urandom_range(1, 40000)) * f;
    end
    if ($urandom_range(0, 19) == 0) q.da = 0;
    if ($urandom_range(0, 19) == 0) q.nb = 0;
    return q;
  endfunction

  task automatic send_beat(frac_req_t q);
    while (!no_idle && $urandom_range(0, 99) < 7) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    kind <= q.kind; num_a <= q.na; den_a <= q.da; num_b <= q.nb; den_b <= q.db;
    @(posedge clk);
    while (full) @(posedge clk);
    quotient_q.push_back(predict_quotient(q));
  endtask

  // receiver hold-off, counted down in cycles
  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      hold_rx <= 3000;
      hold_seen <= 1'b1;
    end else if (hold_rx > 0) begin
      hold_rx <= hold_rx - 1;
    end
  end

  // result side
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && pop && !empty) begin
      if (quotient_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %0d", status);
      end else begin
        frac_res_t e;
        e = quotient_q.pop_front();
        if (status !== e.st || num_out !== e.num || den_out !== e.den) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d %0d/%0d got st=%0d %0d/%0d",
                     e.st, $signed(e.num), e.den, status, num_out, den_out);
        end
      end
    end
    if (hold_rx > 0) pop <= 1'b0;
    else pop <= rst ? 1'b0 : (no_idle || $urandom_range(0, 99) >= 7);
  end

  table_row_t rows[$];

  initial begin
    frac_req_t q;
    rows = '{
      '{'{0, 32'd6, 32'd4, 0, 0}, 1, '{ST_OK, 32'd3, 31'd2}},
      '{'{0, 32'd0, 32'd5, 0, 0}, 1, '{ST_OK, 32'd0, 31'd1}},
      '{'{0, 32'd0, 32'd0, 0, 0}, 1, '{ST_ZERO_DEN, 32'd0, 31'd0}},
      '{'{0, 32'd7, 32'd0, 0, 0}, 1, '{ST_ZERO_DEN, 32'd0, 31'd0}},
      '{'{0, 32'd3, -32'd9, 0, 0}, 1, '{ST_OK, -32'd1, 31'd3}},
      '{'{0, -32'd4, -32'd8, 32'hffffffff, 0}, 1, '{ST_OK, 32'd1, 31'd2}},
      '{'{0, 32'h80000000, 32'd1, 0, 0}, 1, '{ST_OVERFLOW, 32'd0, 31'd0}},
      '{'{0, 32'd1, 32'h80000000, 0, 0}, 1, '{ST_OVERFLOW, 32'd0, 31'd0}},
      '{'{0, 32'h80000000, 32'd2, 0, 0}, 0, '{ST_OK, 0, 0}},
      '{'{0, 32'h7fffffff, 32'h80000001, 0, 0}, 1, '{ST_OK, -32'd1, 31'd1}},
      '{'{0, 32'h7fffffff, 32'd1, 0, 0}, 1, '{ST_OK, 32'h7fffffff, 31'd1}},
      '{'{1, 32'd1, 32'd2, 32'd3, 32'd0}, 1, '{ST_ZERO_DEN, 32'd0, 31'd0}},
      '{'{1, 32'd1, 32'd0, 32'd0, 32'd4}, 1, '{ST_ZERO_DEN, 32'd0, 31'd0}},
      '{'{1, 32'd1, 32'd2, 32'd0, 32'd4}, 1, '{ST_DIV_ZERO, 32'd0, 31'd0}},
      '{'{1, 32'd1, 32'd2, 32'd3, 32'd4}, 0, '{ST_OK, 0, 0}},
      '{'{1, 32'h7fffffff, 32'd1, 32'd1, 32'h7fffffff}, 0, '{ST_OK, 0, 0}},
      '{'{1, 32'h7fffffff, 32'h7fffffff, 32'h80000001, 32'h80000001}, 0,
        '{ST_OK, 0, 0}},
      '{'{1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000}, 0,
        '{ST_OK, 0, 0}},
      '{'{1, 32'd0, -32'd5, 32'd7, -32'd3}, 0, '{ST_OK, 0, 0}},
      '{'{1, 32'h55555555, 32'haaaaaaaa, 32'h33333333, 32'hcccccccc}, 0,
        '{ST_OK, 0, 0}}
    };
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      send_beat(rows[i].req);
      if (rows[i].known) quotient_q[$] = rows[i].res;
    end
    push <= 1'b0;
    // pause until drained
    while (quotient_q.size() != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 300) hold_req = 1'b1;  // receiver stalls, input backs up
      no_idle = (i >= 600 && i < 800);
      q = rand_req();
      send_beat(q);
    end
    push <= 1'b0;
    while (quotient_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/rdr_pkg.sv
rtl/rdr_front.sv
rtl/rdr_fifo.sv
rtl/rdr_back.sv
rtl/rational_divide_reduce_top.sv
test/tb_rational_divide_reduce_top.sv
